// File: src/fbfc_pkg.sv
package fbfc_pkg;

  localparam int unsigned TimeoutW = 32;
  localparam logic [TimeoutW-1:0] DefaultTimeoutMs = 32'd30000;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_BACK = 2'd2;

  localparam logic [1:0] SPEED_STOP   = 2'd0;
  localparam logic [1:0] SPEED_NORMAL = 2'd1;
  localparam logic [1:0] SPEED_JOG    = 2'd2;

  localparam logic [1:0] JOG_NONE = 2'd0;
  localparam logic [1:0] JOG_REV  = 2'd1;
  localparam logic [1:0] JOG_FWD  = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic req_type;
    logic pos_low;
    logic pos_mid;
    logic pos_high;
    logic runout;
    logic jog_reverse;
    logic jog_forward;
  } req_t;

  typedef struct packed {
    logic       motor_enable;
    logic       motor_reverse;
    logic [1:0] speed_select;
    logic       current_boost;
    logic       filament_present;
    logic       error_led;
    logic       forward_led;
    logic       reverse_led;
    logic       fault;
  } rsp_t;

  typedef struct packed {
    logic [1:0]          drive_mode;
    logic [1:0]          prev_mode;
    logic                pushing;
    logic [TimeoutW-1:0] push_ms;
    logic                fault;
    logic                enable;
    logic                reverse;
    logic [1:0]          speed;
    logic                boost;
    logic                lamp_fil;
    logic                lamp_err;
    logic                lamp_fwd;
    logic                lamp_rev;
    logic [1:0]          jog_key;
  } ctl_state_t;

endpackage

// File: src/fbfc_step.sv
module fbfc_step (
  input  fbfc_pkg::req_t                   req_i,
  input  fbfc_pkg::ctl_state_t             state_i,
  input  logic [fbfc_pkg::TimeoutW-1:0]    timeout_i,
  output fbfc_pkg::ctl_state_t             state_o,
  output fbfc_pkg::rsp_t                   rsp_o
);
  import fbfc_pkg::*;

  ctl_state_t s;
  logic       done;
  logic       held;

  always_comb begin
    s    = state_i;
    done = 1'b0;
    held = 1'b0;
    if (req_i.req_type == REQ_TICK) begin
      if (s.pushing) begin
        if (s.push_ms != '1) begin
          s.push_ms = s.push_ms + TimeoutW'(1);
        end
        if (s.push_ms > timeout_i) begin
          s.fault    = 1'b1;
          s.lamp_err = 1'b1;
        end
      end
    end else begin
      if (s.jog_key != JOG_NONE) begin
        held = (s.jog_key == JOG_REV) ? req_i.jog_reverse : req_i.jog_forward;
        if (held) begin
          done = 1'b1;
        end else begin
          // key released: stop, then fall through to the normal rules
          s.speed      = SPEED_STOP;
          s.drive_mode = MODE_STOP;
          s.pushing    = 1'b0;
          s.push_ms    = '0;
          s.fault      = 1'b0;
          s.enable     = 1'b0;
          s.lamp_fwd   = 1'b0;
          s.lamp_rev   = 1'b0;
          s.jog_key    = JOG_NONE;
        end
      end else if (req_i.jog_reverse || req_i.jog_forward) begin
        s.jog_key  = req_i.jog_reverse ? JOG_REV : JOG_FWD;
        s.lamp_fwd = !req_i.jog_reverse;
        s.lamp_rev = req_i.jog_reverse;
        s.enable   = 1'b1;
        s.boost    = 1'b1;
        s.reverse  = req_i.jog_reverse;
        s.speed    = SPEED_JOG;
        done       = 1'b1;
      end

      if (!done) begin
        if (req_i.runout) begin
          s.speed      = SPEED_STOP;
          s.drive_mode = MODE_STOP;
          s.lamp_fil   = 1'b0;
          s.pushing    = 1'b0;
          s.push_ms    = '0;
          s.fault      = 1'b0;
          s.enable     = 1'b0;
          s.lamp_fwd   = 1'b0;
          s.lamp_rev   = 1'b0;
        end else begin
          s.lamp_fil = 1'b1;
          if (s.fault) begin
            s.speed      = SPEED_STOP;
            s.drive_mode = MODE_STOP;
            s.enable     = 1'b0;
            s.lamp_err   = 1'b1;
            s.lamp_fwd   = 1'b0;
            s.lamp_rev   = 1'b0;
          end else begin
            if (req_i.pos_low) begin
              s.prev_mode  = s.drive_mode;
              s.drive_mode = MODE_FWD;
              s.pushing    = 1'b1;
            end else if (req_i.pos_mid) begin
              s.prev_mode  = s.drive_mode;
              s.drive_mode = MODE_STOP;
              s.pushing    = 1'b0;
              s.push_ms    = '0;
            end else if (req_i.pos_high) begin
              s.prev_mode  = s.drive_mode;
              s.drive_mode = MODE_BACK;
              s.pushing    = 1'b0;
              s.push_ms    = '0;
            end
            // drive outputs only move on a mode change
            if (s.drive_mode != s.prev_mode) begin
              case (s.drive_mode)
                MODE_FWD: begin
                  s.lamp_err = 1'b0;
                  s.lamp_fwd = 1'b1;
                  s.enable   = 1'b1;
                  s.boost    = 1'b0;
                  s.reverse  = 1'b0;
                  s.speed    = SPEED_NORMAL;
                end
                MODE_BACK: begin
                  s.lamp_err = 1'b0;
                  s.lamp_rev = 1'b1;
                  s.enable   = 1'b1;
                  s.boost    = 1'b0;
                  s.reverse  = 1'b1;
                  s.speed    = SPEED_NORMAL;
                end
                default: begin
                  s.lamp_fwd = 1'b0;
                  s.lamp_rev = 1'b0;
                  s.enable   = 1'b0;
                  s.speed    = SPEED_STOP;
                end
              endcase
            end
          end
        end
      end
    end
  end

  assign state_o = s;

  always_comb begin
    rsp_o.motor_enable     = s.enable;
    rsp_o.motor_reverse    = s.reverse;
    rsp_o.speed_select     = s.speed;
    rsp_o.current_boost    = s.boost;
    rsp_o.filament_present = s.lamp_fil;
    rsp_o.error_led        = s.lamp_err;
    rsp_o.forward_led      = s.lamp_fwd;
    rsp_o.reverse_led      = s.lamp_rev;
    rsp_o.fault            = s.fault;
  end

endmodule

// File: src/filament_buffer_feed_control.sv
// A beat goes from the input register to the result register, held back only while
// a waiting result is held by out_ready_i low. Throughput: one beat per cycle while
// no result waits on out_ready_i low; the decision for a beat is one combinational
// pass from the input register to the result register and the control state.
// Reset (rst_ni low, async): state to stopped, motor enable on, lamps off,
// counters and fault clear, push timeout back to 30000 ms, both stages empty.
module filament_buffer_feed_control (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fbfc_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fbfc_pkg::rsp_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fbfc_pkg::TimeoutW-1:0]   cfg_data_i
);
  import fbfc_pkg::*;

  logic                in_valid_q;
  req_t                in_q;
  logic                out_valid_q;
  rsp_t                out_q;
  logic [TimeoutW-1:0] timeout_q;
  ctl_state_t          st_q;
  ctl_state_t          st_d;
  rsp_t                rsp_d;
  logic                advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  fbfc_step u_step (
    .req_i     (in_q),
    .state_i   (st_q),
    .timeout_i (timeout_q),
    .state_o   (st_d),
    .rsp_o     (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= DefaultTimeoutMs;
      st_q.drive_mode <= MODE_STOP;
      st_q.prev_mode  <= MODE_STOP;
      st_q.pushing    <= 1'b0;
      st_q.push_ms    <= '0;
      st_q.fault      <= 1'b0;
      st_q.enable     <= 1'b1;
      st_q.reverse    <= 1'b0;
      st_q.speed      <= SPEED_STOP;
      st_q.boost      <= 1'b0;
      st_q.lamp_fil   <= 1'b0;
      st_q.lamp_err   <= 1'b0;
      st_q.lamp_fwd   <= 1'b0;
      st_q.lamp_rev   <= 1'b0;
      st_q.jog_key    <= JOG_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  // fault is only ever raised together with the error lamp
  a_fault_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.fault |-> st_q.lamp_err)
    else $error("fault latched without error lamp");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pushing |-> (st_q.push_ms == '0))
    else $error("push counter running while not pushing");

  a_jog_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.jog_key != JOG_NONE) |-> (st_q.speed == SPEED_JOG && st_q.enable && st_q.boost))
    else $error("jog active without jog drive");

  a_jog_boost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.speed_select == SPEED_JOG) |-> out_data_o.current_boost)
    else $error("jog speed without current boost");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed beat produced no result");

endmodule
